[design/avc_pkg.sv]
package avc_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF     = 32;

    localparam int PULSE_TIME_BITS = 32;
    localparam int CLASS_BITS      = 2;
    localparam int WINDOW_BITS     = 16;
    localparam int COUNT_BITS      = 16;
    localparam int CFG_IDX_BITS    = 2;
    localparam int OUT_DATA_BITS   = 24;

    localparam logic [CLASS_BITS-1:0] CLS_BEAM    = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLS_MUON    = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLS_SCINT   = 2'd2;
    localparam logic [CLASS_BITS-1:0] CLS_SILICON = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_MUON_WIN    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCINT_WIN   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SILICON_WIN = 2'd2;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd100;

    typedef struct packed {
        logic [WINDOW_BITS-1:0] muon;
        logic [WINDOW_BITS-1:0] scint;
        logic [WINDOW_BITS-1:0] silicon;
        logic [WINDOW_BITS-1:0] maxw;
    } t_windows;

    typedef struct packed {
        logic                  vld;
        logic                  blk_end;
        logic [CLASS_BITS-1:0] cls;
        logic                  placed;
    } t_tok_ctl;

endpackage

[design/avc_cell.sv]
module avc_cell #(
    parameter int TIME_BITS = avc_pkg::TIME_BITS_DEF,
    parameter int CNT_BITS  = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  avc_pkg::t_windows    i_win,
    input  avc_pkg::t_tok_ctl    i_ctl,
    input  logic [TIME_BITS-1:0] i_time,
    input  logic [CNT_BITS-1:0]  i_cnt,
    output avc_pkg::t_tok_ctl    o_ctl,
    output logic [TIME_BITS-1:0] o_time,
    output logic [CNT_BITS-1:0]  o_cnt
);
    import avc_pkg::*;

    logic                 r_valid, n_valid;
    logic                 r_vetoed, n_vetoed;
    logic [TIME_BITS-1:0] r_time, n_time;
    t_tok_ctl             r_ctl, n_ctl;
    logic [TIME_BITS-1:0] r_tok_time;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;

    logic [WINDOW_BITS-1:0] win_sel;
    logic [TIME_BITS-1:0]   age;
    logic                   hit;
    logic                   aged;
    logic                   veto_now;
    logic                   inc;

    always_comb begin
        unique case (i_ctl.cls)
            CLS_BEAM:    win_sel = '0;
            CLS_MUON:    win_sel = i_win.muon;
            CLS_SCINT:   win_sel = i_win.scint;
            CLS_SILICON: win_sel = i_win.silicon;
            default:     win_sel = '0;
        endcase
    end

    assign age      = i_time - r_time;
    assign hit      = age < TIME_BITS'(win_sel);
    assign aged     = age >= TIME_BITS'(i_win.maxw);
    assign veto_now = r_vetoed | hit;

    always_comb begin
        n_valid  = r_valid;
        n_vetoed = r_vetoed;
        n_time   = r_time;
        n_ctl    = i_ctl;
        inc      = 1'b0;
        if (i_ctl.vld) begin
            if (i_ctl.blk_end) begin
                inc      = r_valid & ~r_vetoed;
                n_valid  = 1'b0;
                n_vetoed = 1'b0;
            end else begin
                if (r_valid && aged) begin
                    inc      = ~veto_now;
                    n_valid  = 1'b0;
                    n_vetoed = 1'b0;
                end else if (r_valid) begin
                    n_vetoed = veto_now;
                end
                if (i_ctl.cls == CLS_BEAM && !i_ctl.placed && !n_valid) begin
                    n_valid      = 1'b1;
                    n_vetoed     = 1'b0;
                    n_time       = i_time;
                    n_ctl.placed = 1'b1;
                end
            end
        end
        n_cnt = i_cnt + CNT_BITS'(inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_vetoed  <= 1'b0;
            r_ctl     <= '0;
        end else if (i_adv) begin
            r_valid   <= n_valid;
            r_vetoed  <= n_vetoed;
            r_ctl     <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_time     <= n_time;
            r_tok_time <= i_time;
            r_cnt      <= n_cnt;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_time = r_tok_time;
    assign o_cnt  = r_cnt;

endmodule

[design/anticoincidence_veto_counter_unit.sv]
// channel   | signals                                   | beat carries
// ----------+-------------------------------------------+------------------------------
// s_axis    | tvalid tready tdata[31:0] tuser tlast     | pulse_time, channel_class,
//           |                                           | block_end
// m_axis    | tvalid tready tdata[23:0]                 | stopped_count, candidates_dropped
// cfg       | i_cfg_valid o_cfg_ready index data        | veto window register write
//
// One input beat per cycle while the row is not stalled. Each beat passes through the
// PENDING_DEPTH cells in turn; a block_end beat at the tail loads its result for output.
// The row stalls only while a finished result waits at the tail and the output
// register is still held by m_axis_tready low.
// Synchronous active-low reset clears the store, counters and output valid;
// windows reset to 100 ticks.
module anticoincidence_veto_counter_unit #(
    parameter int PENDING_DEPTH = avc_pkg::PENDING_DEPTH_DEF,
    parameter int TIME_BITS     = avc_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [avc_pkg::PULSE_TIME_BITS-1:0] s_axis_tdata,  // [31:0] pulse_time
    input  logic [avc_pkg::CLASS_BITS-1:0]      s_axis_tuser,  // [1:0] channel_class
    input  logic                                s_axis_tlast,  // block_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [avc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // [15:0] stopped_count, [16] candidates_dropped, [23:17] zero
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [avc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [avc_pkg::WINDOW_BITS-1:0]     i_cfg_data
);
    import avc_pkg::*;

    localparam int CNT_BITS = $clog2(PENDING_DEPTH + 1);

    logic [WINDOW_BITS-1:0] r_muon_win, r_scint_win, r_silicon_win;
    t_windows               win;
    logic [WINDOW_BITS-1:0] max_ms;

    t_tok_ctl             w_ctl  [0:PENDING_DEPTH];
    logic [TIME_BITS-1:0] w_time [0:PENDING_DEPTH];
    logic [CNT_BITS-1:0]  w_cnt  [0:PENDING_DEPTH];

    logic [63:0]           time_ext;
    logic                  adv;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] sat;

    logic [COUNT_BITS-1:0] r_clean;
    logic                  r_ovf;
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_drop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_muon_win    <= WINDOW_RESET;
            r_scint_win   <= WINDOW_RESET;
            r_silicon_win <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MUON_WIN:    r_muon_win    <= i_cfg_data;
                REG_SCINT_WIN:   r_scint_win   <= i_cfg_data;
                REG_SILICON_WIN: r_silicon_win <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign max_ms      = (r_scint_win > r_muon_win) ? r_scint_win : r_muon_win;
    assign win.muon    = r_muon_win;
    assign win.scint   = r_scint_win;
    assign win.silicon = r_silicon_win;
    assign win.maxw    = (r_silicon_win > max_ms) ? r_silicon_win : max_ms;

    assign adv = !(w_ctl[PENDING_DEPTH].vld && w_ctl[PENDING_DEPTH].blk_end &&
                   r_out_valid && !m_axis_tready);
    assign s_axis_tready = adv;

    assign time_ext         = {32'b0, s_axis_tdata};
    assign w_ctl[0].vld     = s_axis_tvalid;
    assign w_ctl[0].blk_end = s_axis_tlast;
    assign w_ctl[0].cls     = s_axis_tuser;
    assign w_ctl[0].placed  = 1'b0;
    assign w_time[0]        = time_ext[TIME_BITS-1:0];
    assign w_cnt[0]         = '0;

    for (genvar k = 0; k < PENDING_DEPTH; k++) begin : g_cell
        avc_cell #(
            .TIME_BITS (TIME_BITS),
            .CNT_BITS  (CNT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_win   (win),
            .i_ctl   (w_ctl[k]),
            .i_time  (w_time[k]),
            .i_cnt   (w_cnt[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_time  (w_time[k+1]),
            .o_cnt   (w_cnt[k+1])
        );
    end

    assign sum = {1'b0, r_clean} + (COUNT_BITS+1)'(w_cnt[PENDING_DEPTH]);
    assign sat = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clean     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv && w_ctl[PENDING_DEPTH].vld && w_ctl[PENDING_DEPTH].blk_end) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (adv && w_ctl[PENDING_DEPTH].vld) begin
                if (w_ctl[PENDING_DEPTH].blk_end) begin
                    r_clean     <= '0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_clean <= sat;
                    if (w_ctl[PENDING_DEPTH].cls == CLS_BEAM && !w_ctl[PENDING_DEPTH].placed) begin
                        r_ovf <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && w_ctl[PENDING_DEPTH].vld && w_ctl[PENDING_DEPTH].blk_end) begin
            r_out_count <= sat;
            r_out_drop  <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_drop, r_out_count};

endmodule

[tb/anticoincidence_veto_counter_unit_tb.sv]
module anticoincidence_veto_counter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import avc_pkg::*;

    localparam int DEPTH          = PENDING_DEPTH_DEF;
    localparam int SETTLE_CYCLES  = DEPTH + 8;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int HOLD_CYCLES    = 300;
    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [CLASS_BITS-1:0]      cls;
        logic [PULSE_TIME_BITS-1:0] stamp;
        logic                       ends_block;
    } pulse_beat_t;

    typedef struct {
        logic [COUNT_BITS-1:0] stopped;
        logic                  dropped;
    } block_tally_t;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [PULSE_TIME_BITS-1:0] s_axis_tdata = '0;
    logic [CLASS_BITS-1:0]      s_axis_tuser = '0;
    logic                       s_axis_tlast = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]   m_axis_tdata;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index = '0;
    logic [WINDOW_BITS-1:0]     i_cfg_data = '0;

    anticoincidence_veto_counter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // veto window copy and candidate store
    logic [WINDOW_BITS-1:0]     win_muon    = WINDOW_RESET;
    logic [WINDOW_BITS-1:0]     win_scint   = WINDOW_RESET;
    logic [WINDOW_BITS-1:0]     win_silicon = WINDOW_RESET;
    logic [PULSE_TIME_BITS-1:0] cand_stamp [DEPTH];
    bit                         cand_live [DEPTH];
    bit                         cand_vetoed [DEPTH];
    logic [COUNT_BITS-1:0]      clean_tally = '0;
    bit                         tally_overflow;

    block_tally_t expected_tallies [$];
    pulse_beat_t  pending_pulses [$];

    logic [CLASS_BITS-1:0] veto_classes [3] = '{CLS_MUON, CLS_SCINT, CLS_SILICON};

    bit          pulse_taken;
    bit          result_taken;
    bit          cfg_taken;
    int          mismatches;
    int unsigned cycle_count;

    int send_gap;
    bit send_idle_on = 1'b1;
    bit send_steady;
    int recv_wait;
    bit recv_idle_on;
    int hold_left;
    bit hold_arm;

    logic [PULSE_TIME_BITS-1:0] stream_now;

    function automatic logic [WINDOW_BITS-1:0] widest_window();
        logic [WINDOW_BITS-1:0] w;
        w = win_muon;
        if (win_scint > w) w = win_scint;
        if (win_silicon > w) w = win_silicon;
        return w;
    endfunction

    function automatic void bump_clean();
        if (clean_tally != '1) clean_tally++;
    endfunction

    task automatic tally_pulse(input pulse_beat_t b);
        logic [WINDOW_BITS-1:0]     widest;
        logic [WINDOW_BITS-1:0]     reach;
        logic [PULSE_TIME_BITS-1:0] age;
        block_tally_t               t;
        bit                         placed;
        if (b.ends_block) begin
            for (int i = 0; i < DEPTH; i++)
                if (cand_live[i] && !cand_vetoed[i]) bump_clean();
            t.stopped = clean_tally;
            t.dropped = tally_overflow;
            expected_tallies = {expected_tallies, t};
            for (int i = 0; i < DEPTH; i++) begin
                cand_live[i] = 1'b0;
                cand_vetoed[i] = 1'b0;
            end
            clean_tally = '0;
            tally_overflow = 1'b0;
            return;
        end
        widest = widest_window();
        case (b.cls)
            CLS_MUON:    reach = win_muon;
            CLS_SCINT:   reach = win_scint;
            CLS_SILICON: reach = win_silicon;
            default:     reach = '0;
        endcase
        for (int i = 0; i < DEPTH; i++) begin
            if (!cand_live[i]) continue;
            age = b.stamp - cand_stamp[i];
            if (b.cls != CLS_BEAM && age < reach) cand_vetoed[i] = 1'b1;
            // out of reach of every class: retire
            if (age >= widest) begin
                if (!cand_vetoed[i]) bump_clean();
                cand_live[i] = 1'b0;
                cand_vetoed[i] = 1'b0;
            end
        end
        if (b.cls == CLS_BEAM) begin
            placed = 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                if (!placed && !cand_live[i]) begin
                    cand_live[i] = 1'b1;
                    cand_vetoed[i] = 1'b0;
                    cand_stamp[i] = b.stamp;
                    placed = 1'b1;
                end
            end
            if (!placed) tally_overflow = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        pulse_beat_t  got;
        block_tally_t want;
        pulse_taken  = i_rst_n && s_axis_tvalid && s_axis_tready;
        result_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        cfg_taken    = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (pulse_taken) begin
            got.cls = s_axis_tuser;
            got.stamp = s_axis_tdata;
            got.ends_block = s_axis_tlast;
            tally_pulse(got);
        end
        if (cfg_taken) begin
            case (i_cfg_index)
                REG_MUON_WIN:    win_muon = i_cfg_data;
                REG_SCINT_WIN:   win_scint = i_cfg_data;
                REG_SILICON_WIN: win_silicon = i_cfg_data;
                default: ;
            endcase
        end
        if (result_taken) begin
            if (expected_tallies.size() == 0) begin
                report_mismatch("result with none pending", 32'(m_axis_tdata), 32'd0);
            end else begin
                want = expected_tallies.pop_front();
                if (m_axis_tdata[COUNT_BITS-1:0] != want.stopped)
                    report_mismatch("stopped_count", 32'(m_axis_tdata[COUNT_BITS-1:0]),
                                    32'(want.stopped));
                if (m_axis_tdata[COUNT_BITS] != want.dropped)
                    report_mismatch("candidates_dropped", 32'(m_axis_tdata[COUNT_BITS]),
                                    32'(want.dropped));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin : pulse_driver
        pulse_beat_t nxt;
        if (i_rst_n && (!s_axis_tvalid || pulse_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pulses.size() != 0) begin
                nxt = pending_pulses.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= nxt.stamp;
                s_axis_tuser <= nxt.cls;
                s_axis_tlast <= nxt.ends_block;
                if ($urandom_range(0, 39) == 0) send_idle_on = !send_idle_on;
                send_gap = (send_idle_on && !send_steady) ? $urandom_range(0, 19) : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, armed from the stimulus
    always @(posedge i_clk) begin : holdoff
        if (hold_arm) begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    always @(negedge i_clk) begin : result_sink
        if (result_taken) begin
            if ($urandom_range(0, 15) == 0) recv_idle_on = !recv_idle_on;
            recv_wait = recv_idle_on ? $urandom_range(0, 19) : 0;
        end
        if (!i_rst_n || hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_pulse(input logic [CLASS_BITS-1:0] cls,
                               input logic [PULSE_TIME_BITS-1:0] stamp, input logic ends);
        pulse_beat_t b;
        b.cls = cls;
        b.stamp = stamp;
        b.ends_block = ends;
        pending_pulses = {pending_pulses, b};
    endtask

    task automatic queue_block(input int len);
        int unsigned span;
        int unsigned r;
        logic [CLASS_BITS-1:0] cls;
        span = 2 * widest_window() + 2;
        for (int k = 0; k < len; k++) begin
            cls = ($urandom_range(0, 99) < 45) ? CLS_BEAM : veto_classes[$urandom_range(0, 2)];
            r = $urandom_range(0, 99);
            if (r < 30) stream_now += $urandom_range(0, 2);
            else if (r < 85) stream_now += $urandom_range(0, span);
            else if (r < 97) stream_now += $urandom_range(0, 200000);
            else stream_now += $urandom();
            queue_pulse(cls, stream_now, 1'b0);
        end
        // pulse fields of the closing beat are don't-care: randomize them
        queue_pulse(CLASS_BITS'($urandom_range(0, 3)), $urandom(), 1'b1);
    endtask

    task automatic queue_blocks(input int beats);
        int len;
        int r;
        while (beats > 0) begin
            r = $urandom_range(0, 9);
            if (r == 0) len = 0;
            else if (r < 8) len = $urandom_range(1, 12);
            else len = $urandom_range(13, 40);
            queue_block(len);
            beats -= len + 1;
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pulses.size() != 0 || s_axis_tvalid || expected_tallies.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [WINDOW_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk);
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_windows(input logic [WINDOW_BITS-1:0] muon,
                               input logic [WINDOW_BITS-1:0] scint,
                               input logic [WINDOW_BITS-1:0] silicon);
        write_register(REG_MUON_WIN, muon);
        write_register(REG_SCINT_WIN, scint);
        write_register(REG_SILICON_WIN, silicon);
    endtask

    function automatic logic [WINDOW_BITS-1:0] pick_window();
        return ($urandom_range(0, 2) == 0) ? WINDOW_BITS'($urandom_range(0, 65535))
                                           : WINDOW_BITS'($urandom_range(0, 300));
    endfunction

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // equal-time veto, veto just inside and just at the window
        queue_pulse(CLS_BEAM, 32'd0, 1'b0);
        queue_pulse(CLS_MUON, 32'd0, 1'b0);
        queue_pulse(CLS_BEAM, 32'd10, 1'b0);
        queue_pulse(CLS_SCINT, 32'd109, 1'b0);
        queue_pulse(CLS_BEAM, 32'd200, 1'b0);
        queue_pulse(CLS_SILICON, 32'd300, 1'b0);
        // distance across the time wrap
        queue_pulse(CLS_BEAM, 32'hFFFF_FFF0, 1'b0);
        queue_pulse(CLS_SILICON, 32'h0000_0005, 1'b0);
        queue_pulse(CLS_SILICON, 32'hFFFF_FFFF, 1'b1);
        // one beam more than the store holds
        repeat (DEPTH + 1) queue_pulse(CLS_BEAM, 32'd1000, 1'b0);
        queue_pulse(CLS_BEAM, 32'd0, 1'b1);
        stream_now = 32'd2000;
        queue_blocks(150);
        wait_idle();

        // zero windows: nothing vetoes, everything retires at once
        set_windows(16'd0, 16'd0, 16'd0);
        write_register(REG_SPARE, WINDOW_BITS'($urandom()));
        queue_blocks(120);
        wait_idle();

        set_windows(16'hFFFF, 16'd0, 16'd1);
        queue_blocks(120);
        wait_idle();

        set_windows(16'd7, 16'd30, 16'd2);
        queue_blocks(120);
        wait_idle();

        // back-pressure: sink holds off while short blocks stream in
        set_windows(16'd20, 16'd40, 16'd10);
        send_steady = 1'b1;
        hold_arm = 1'b1;
        repeat (16) queue_block($urandom_range(0, 4));
        wait_idle();
        send_steady = 1'b0;

        repeat (4) begin
            set_windows(pick_window(), pick_window(), pick_window());
            queue_blocks(110);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
